/* sv/assert_macros.svh */
// Assertion macros for the connection limiter blocks.
// Define ASSERT_OFF to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* sv/pscl_pkg.sv */
`timescale 1ns / 1ps

package pscl_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned TOTAL_W     = 16;
  localparam int unsigned LIMIT_W     = 16;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned OUT_TDATA_W = 24;

  // Operation codes carried in tuser
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LIMIT = 2'd1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_GRANTED         = 3'd0,
    STAT_TOTAL_LIMIT     = 3'd1,
    STAT_SOURCE_LIMIT    = 3'd2,
    STAT_TABLE_FULL      = 3'd3,
    STAT_RELEASED        = 3'd4,
    STAT_RELEASE_UNKNOWN = 3'd5
  } status_e;

  // Table access strobes from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_valid;
  } tbl_cmd_t;

endpackage

/* sv/per_source_connection_limiter_unit.sv */
`timescale 1ns / 1ps
// An input item is accepted only while the sequencer is idle, so a new item waits until the
// last one has passed SCAN, DRAIN and DECIDE and its result is registered; the sequencer reads
// one table entry per cycle through the single memory read port and compares it with the shared comparator.
// Reset (rst_ni low, asynchronous): total count zero, all entries invalid, limits zero
// (unlimited), no result pending. The table memory itself is not cleared.

module per_source_connection_limiter_unit import pscl_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [LIMIT_W-1:0]     cfg_data_i,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [ADDR_W-1:0]      s_axis_tdata,   // [31:0] source_addr
  input  logic [0:0]             s_axis_tuser,   // [0] op
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [2:0] status, [18:3] open_total, rest 0
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [LIMIT_W-1:0]    total_limit_q;
  logic [LIMIT_W-1:0]    source_limit_q;
  status_e               out_status;
  logic [TOTAL_W-1:0]    out_total;
  tbl_cmd_t              tbl_cmd;
  logic [IDX_W-1:0]      tbl_rd_idx;
  logic [IDX_W-1:0]      tbl_wr_idx;
  logic [ADDR_W-1:0]     tbl_wr_addr;
  logic [COUNT_BITS-1:0] tbl_wr_count;
  logic                  tbl_rd_valid;
  logic [ADDR_W-1:0]     tbl_rd_addr;
  logic [COUNT_BITS-1:0] tbl_rd_count;

  // Limit registers; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_limit_q  <= '0;
      source_limit_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_TOTAL_LIMIT) begin
        total_limit_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_SOURCE_LIMIT) begin
        source_limit_q <= cfg_data_i;
      end
    end
  end

  pscl_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .total_limit_i  (total_limit_q),
    .source_limit_i (source_limit_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_op_i        (s_axis_tuser[0]),
    .in_addr_i      (s_axis_tdata),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_status_o   (out_status),
    .out_total_o    (out_total),
    .tbl_cmd_o      (tbl_cmd),
    .tbl_rd_idx_o   (tbl_rd_idx),
    .tbl_wr_idx_o   (tbl_wr_idx),
    .tbl_wr_addr_o  (tbl_wr_addr),
    .tbl_wr_count_o (tbl_wr_count),
    .tbl_rd_valid_i (tbl_rd_valid),
    .tbl_rd_addr_i  (tbl_rd_addr),
    .tbl_rd_count_i (tbl_rd_count)
  );

  pscl_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (tbl_cmd),
    .rd_idx_i   (tbl_rd_idx),
    .wr_idx_i   (tbl_wr_idx),
    .wr_addr_i  (tbl_wr_addr),
    .wr_count_i (tbl_wr_count),
    .rd_valid_o (tbl_rd_valid),
    .rd_addr_o  (tbl_rd_addr),
    .rd_count_o (tbl_rd_count)
  );

  // Result packing, status in the low bits
  assign m_axis_tdata = {
    {(OUT_TDATA_W - TOTAL_W - STATUS_W){1'b0}}, out_total, out_status
  };

endmodule

/* sv/pscl_table.sv */
`timescale 1ns / 1ps

module pscl_table import pscl_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COUNT_BITS    = 16,
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tbl_cmd_t              cmd_i,
  input  logic [IDX_W-1:0]      rd_idx_i,
  input  logic [IDX_W-1:0]      wr_idx_i,
  input  logic [ADDR_W-1:0]     wr_addr_i,
  input  logic [COUNT_BITS-1:0] wr_count_i,
  output logic                  rd_valid_o,
  output logic [ADDR_W-1:0]     rd_addr_o,
  output logic [COUNT_BITS-1:0] rd_count_o
);

  localparam int unsigned WORD_W = COUNT_BITS + ADDR_W;

  // Address and count memory, one read and one write port
  logic [WORD_W-1:0]        mem_q [TABLE_ENTRIES];
  logic [WORD_W-1:0]        rd_word_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic                     rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_idx_i] <= {wr_count_i, wr_addr_i};
    end
    if (cmd_i.rd_en) begin
      rd_word_q <= mem_q[rd_idx_i];
    end
  end

  // Valid bits in flops, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        valid_q[wr_idx_i] <= cmd_i.wr_valid;
      end
      if (cmd_i.rd_en) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_addr_o  = rd_word_q[ADDR_W-1:0];
  assign rd_count_o = rd_word_q[WORD_W-1:ADDR_W];

endmodule

/* sv/pscl_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pscl_ctrl import pscl_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COUNT_BITS    = 16,
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [LIMIT_W-1:0]    total_limit_i,
  input  logic [LIMIT_W-1:0]    source_limit_i,
  // input item
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_op_i,
  input  logic [ADDR_W-1:0]     in_addr_i,
  // result item
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output status_e               out_status_o,
  output logic [TOTAL_W-1:0]    out_total_o,
  // table port
  output tbl_cmd_t              tbl_cmd_o,
  output logic [IDX_W-1:0]      tbl_rd_idx_o,
  output logic [IDX_W-1:0]      tbl_wr_idx_o,
  output logic [ADDR_W-1:0]     tbl_wr_addr_o,
  output logic [COUNT_BITS-1:0] tbl_wr_count_o,
  input  logic                  tbl_rd_valid_i,
  input  logic [ADDR_W-1:0]     tbl_rd_addr_i,
  input  logic [COUNT_BITS-1:0] tbl_rd_count_i
);

  localparam int unsigned CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_e;

  state_e                state_q;
  logic                  op_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [IDX_W-1:0]      idx_q;
  logic                  cmp_q;
  logic [IDX_W-1:0]      cmp_idx_q;
  logic                  hit_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [COUNT_BITS-1:0] hit_cnt_q;
  logic                  free_q;
  logic [IDX_W-1:0]      free_idx_q;
  logic [TOTAL_W-1:0]    total_q;
  logic                  out_valid_q;
  status_e               status_q;

  logic                  in_fire;
  logic                  out_free;
  logic                  decide_fire;
  logic                  addr_match;
  status_e               status_d;
  logic [TOTAL_W-1:0]    total_d;
  logic                  wr_en;
  logic                  wr_valid;
  logic [IDX_W-1:0]      wr_idx;
  logic [COUNT_BITS-1:0] wr_count;
  logic                  total_hit;
  logic                  source_hit;
  logic [COUNT_BITS-1:0] cnt_dec;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign decide_fire = (state_q == ST_DECIDE) && out_free;

  // Shared comparator on the entry just read
  assign addr_match = (tbl_rd_addr_i == addr_q);

  // Verdict once the scan has finished
  assign total_hit  = (total_limit_i != '0) && (total_q >= total_limit_i);
  assign source_hit = (source_limit_i != '0) &&
                      (CMP_W'(hit_cnt_q) >= CMP_W'(source_limit_i));
  assign cnt_dec    = (hit_cnt_q == '0) ? '0 : hit_cnt_q - COUNT_BITS'(1);

  always_comb begin
    status_d = STAT_TABLE_FULL;
    total_d  = total_q;
    wr_en    = 1'b0;
    wr_valid = 1'b1;
    wr_idx   = hit_idx_q;
    wr_count = hit_cnt_q;
    if (op_q == OP_ACQUIRE) begin
      priority if (total_hit) begin
        status_d = STAT_TOTAL_LIMIT;
      end else if (hit_q) begin
        if (source_hit) begin
          status_d = STAT_SOURCE_LIMIT;
        end else begin
          status_d = STAT_GRANTED;
          wr_en    = 1'b1;
          wr_count = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + COUNT_BITS'(1);
        end
      end else if (free_q) begin
        status_d = STAT_GRANTED;
        wr_en    = 1'b1;
        wr_idx   = free_idx_q;
        wr_count = COUNT_BITS'(1);
      end else begin
        status_d = STAT_TABLE_FULL;
      end
      if (status_d == STAT_GRANTED && total_q != '1) begin
        total_d = total_q + TOTAL_W'(1);
      end
    end else begin
      if (hit_q) begin
        status_d = STAT_RELEASED;
        wr_en    = 1'b1;
        wr_count = cnt_dec;
        wr_valid = (cnt_dec != '0);
      end else begin
        status_d = STAT_RELEASE_UNKNOWN;
      end
      if (total_q != '0) begin
        total_d = total_q - TOTAL_W'(1);
      end
    end
  end

  // Table strobes
  assign tbl_cmd_o.rd_en    = (state_q == ST_SCAN);
  assign tbl_cmd_o.wr_en    = decide_fire && wr_en;
  assign tbl_cmd_o.wr_valid = wr_valid;
  assign tbl_rd_idx_o       = idx_q;
  assign tbl_wr_idx_o       = wr_idx;
  assign tbl_wr_addr_o      = addr_q;
  assign tbl_wr_count_o     = wr_count;

  // Sequencer, scan trackers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cmp_q       <= 1'b0;
      cmp_idx_q   <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      hit_cnt_q   <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STAT_GRANTED;
      op_q        <= OP_ACQUIRE;
      addr_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !decide_fire) begin
        out_valid_q <= 1'b0;
      end
      cmp_q     <= (state_q == ST_SCAN);
      cmp_idx_q <= idx_q;
      if (cmp_q) begin
        if (tbl_rd_valid_i && addr_match && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= cmp_idx_q;
          hit_cnt_q <= tbl_rd_count_i;
        end
        if (!tbl_rd_valid_i && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= cmp_idx_q;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            op_q    <= in_op_i;
            addr_q  <= in_addr_i;
            idx_q   <= '0;
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx_q == LAST_IDX) begin
            state_q <= ST_DRAIN;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            total_q     <= total_d;
            status_q    <= status_d;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_total_o  = total_q;

  // Checks
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !in_ready_o, "ready while busy")
  `ASSERT_IMPLIES(a_result_from_decide, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_DECIDE), "result outside verdict")
  `ASSERT_IMPLIES(a_hit_free_apart, clk_i, rst_ni, hit_q && free_q, hit_idx_q != free_idx_q, "hit and free slot coincide")
  `ASSERT_IMPLIES(a_write_only_on_verdict, clk_i, rst_ni, tbl_cmd_o.wr_en, state_q == ST_DECIDE, "table written outside verdict")

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import pscl_pkg::*;

  localparam int unsigned TABLE_N = 64;
  localparam int unsigned COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam int unsigned ITEM_CYCLES = TABLE_N + 3;
  localparam int unsigned POOL_N = 96;
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 105;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam longint WATCHDOG_NS = 8_000_000;

  // Register indexes past the two real ones; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    status_e            status;
    logic [TOTAL_W-1:0] open_total;
  } verdict_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [LIMIT_W-1:0]     cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [ADDR_W-1:0]      s_axis_tdata = '0;   // [31:0] source_addr
  logic [0:0]             s_axis_tuser = '0;   // [0] op
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [2:0] status, [18:3] open_total

  // Predicted limiter state
  logic [LIMIT_W-1:0] lim_total;
  logic [LIMIT_W-1:0] lim_source;
  logic [TOTAL_W-1:0] open_count;
  logic               slot_used  [TABLE_N];
  logic [ADDR_W-1:0]  slot_addr  [TABLE_N];
  logic [COUNT_W-1:0] slot_count [TABLE_N];

  verdict_t    verdict_q[$];
  int          n_fail = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          rx_hold_seq = 0;
  int          rx_hold_seen = 0;
  int          rx_hold_len = 0;
  int          rx_hold_left = 0;
  logic [ADDR_W-1:0] addr_pool [POOL_N];

  per_source_connection_limiter_unit #(
    .TABLE_ENTRIES(TABLE_N),
    .COUNT_BITS   (COUNT_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("tb: done, errors");
    $finish;
  end

  // Admission decision for one item; updates the predicted table and total
  function automatic status_e predict_admission(input logic op, input logic [ADDR_W-1:0] addr);
    int      hit;
    int      free_slot;
    int      i;
    status_e st;
    hit = -1;
    free_slot = -1;
    for (i = 0; i < TABLE_N; i++) begin
      if (slot_used[i] && slot_addr[i] == addr && hit < 0) hit = i;
      if (!slot_used[i] && free_slot < 0) free_slot = i;
    end
    if (op == OP_ACQUIRE) begin
      if (lim_total != 0 && open_count >= lim_total) begin
        st = STAT_TOTAL_LIMIT;
      end else if (hit >= 0) begin
        if (lim_source != 0 && slot_count[hit] >= lim_source) begin
          st = STAT_SOURCE_LIMIT;
        end else begin
          if (slot_count[hit] != COUNT_MAX) slot_count[hit]++;
          st = STAT_GRANTED;
        end
      end else if (free_slot < 0) begin
        st = STAT_TABLE_FULL;
      end else begin
        slot_used[free_slot]  = 1'b1;
        slot_addr[free_slot]  = addr;
        slot_count[free_slot] = COUNT_W'(1);
        st = STAT_GRANTED;
      end
      if (st == STAT_GRANTED && open_count != TOTAL_MAX) open_count++;
    end else begin
      st = STAT_RELEASE_UNKNOWN;
      if (hit >= 0) begin
        if (slot_count[hit] != 0) slot_count[hit]--;
        if (slot_count[hit] == 0) slot_used[hit] = 1'b0;
        st = STAT_RELEASED;
      end
      if (open_count != 0) open_count--;
    end
    return st;
  endfunction

  // Offer one item, wait for it to be taken, then record the expected verdict
  task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr);
    verdict_t v;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom();
      s_axis_tuser  <= 1'($urandom_range(1));
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    v.status     = predict_admission(op, addr);
    v.open_total = open_count;
    verdict_q.insert(verdict_q.size(), v);
  endtask

  // Sender stops until every expected verdict has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_TOTAL_LIMIT) lim_total = val;
    else if (idx == CFG_SOURCE_LIMIT) lim_source = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [LIMIT_W-1:0] tot, input logic [LIMIT_W-1:0] src);
    drain();
    write_reg(CFG_TOTAL_LIMIT, tot);
    write_reg(CFG_SOURCE_LIMIT, src);
  endtask

  // Address of a currently open source, chosen at random
  function automatic logic pick_open_source(output logic [ADDR_W-1:0] addr);
    int n;
    int k;
    int i;
    n = 0;
    addr = '0;
    for (i = 0; i < TABLE_N; i++) if (slot_used[i]) n++;
    if (n == 0) return 1'b0;
    k = $urandom_range(n - 1);
    for (i = 0; i < TABLE_N; i++) begin
      if (slot_used[i]) begin
        if (k == 0) addr = slot_addr[i];
        k--;
      end
    end
    return 1'b1;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    verdict_t want;
    logic [STATUS_W-1:0] got_st;
    logic [TOTAL_W-1:0]  got_tot;
    got_st  = m_axis_tdata[STATUS_W-1:0];
    got_tot = m_axis_tdata[STATUS_W +: TOTAL_W];
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result item, status %0d open_total %0d",
                 $time, got_st, got_tot);
        n_fail++;
      end else begin
        want = verdict_q[0];
        verdict_q.delete(0);
        if (got_st != want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, got_st);
          n_fail++;
        end
        if (got_tot != want.open_total) begin
          $display("%0t: open_total mismatch, expected %0d, actual %0d",
                   $time, want.open_total, got_tot);
          n_fail++;
        end
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (rx_hold_seen != rx_hold_seq) begin
      rx_hold_seen  <= rx_hold_seq;
      rx_hold_left  <= rx_hold_len;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left  <= rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Limit checks, their order, unknown releases and release at zero total
  task automatic test_directed();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_item(OP_RELEASE, 32'h0000_0000);
    send_item(OP_ACQUIRE, 32'h0000_0000);
    send_item(OP_ACQUIRE, 32'hFFFF_FFFF);
    send_item(OP_ACQUIRE, 32'h0000_0000);
    send_item(OP_RELEASE, 32'h1234_5678);
    send_item(OP_ACQUIRE, 32'h0000_0000);
    set_limits(16'd0, 16'd2);
    send_item(OP_ACQUIRE, 32'h0000_0000);
    send_item(OP_ACQUIRE, 32'hFFFF_FFFF);
    set_limits(16'd4, 16'd2);
    send_item(OP_ACQUIRE, 32'h8000_0000);
    send_item(OP_ACQUIRE, 32'h0000_0000);
    send_item(OP_RELEASE, 32'h0000_0000);
    send_item(OP_ACQUIRE, 32'h0000_0000);
    send_item(OP_RELEASE, 32'hFFFF_FFFF);
    send_item(OP_RELEASE, 32'hFFFF_FFFF);
    send_item(OP_RELEASE, 32'hFFFF_FFFF);
    // spare indexes must leave both limits alone
    drain();
    write_reg(CFG_SPARE_2, 16'h0001);
    write_reg(CFG_SPARE_3, 16'hFFFF);
    send_item(OP_ACQUIRE, 32'h7FFF_FFFF);
    send_item(OP_ACQUIRE, 32'h0000_0000);
    set_limits(16'hFFFF, 16'hFFFF);
    send_item(OP_ACQUIRE, 32'h0000_0000);
    send_item(OP_RELEASE, 32'h0000_0000);
    send_item(OP_RELEASE, 32'h7FFF_FFFF);
    send_item(OP_RELEASE, 32'h8000_0000);
    set_limits(16'd0, 16'd0);
  endtask

  // Fill every entry, refuse a new source, then reuse a freed entry
  task automatic test_table_full();
    logic [ADDR_W-1:0] a;
    int i;
    int guard;
    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    guard = 0;
    while (guard < 200) begin
      guard++;
      a = 0;
      for (i = 0; i < TABLE_N; i++) if (!slot_used[i]) a = 1;
      if (a == 0) break;
      send_item(OP_ACQUIRE, $urandom());
    end
    send_item(OP_ACQUIRE, $urandom());
    send_item(OP_ACQUIRE, slot_addr[0]);
    // free one entry part way down, then take it with a new source
    a = slot_addr[TABLE_N / 2];
    while (slot_used[TABLE_N / 2] && slot_addr[TABLE_N / 2] == a) send_item(OP_RELEASE, a);
    send_item(OP_ACQUIRE, $urandom());
    send_item(OP_ACQUIRE, $urandom());
    send_item(OP_ACQUIRE, a);
    drain();
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    int i;
    logic [ADDR_W-1:0] a;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_len  = HOLD_CYCLES;
    rx_hold_seq++;
    for (i = 0; i < 30; i++) begin
      if (i % 2 == 1 && pick_open_source(a)) send_item(OP_RELEASE, a);
      else send_item(OP_ACQUIRE, $urandom());
    end
    drain();
  endtask

  // One random item: mostly traffic on a fixed pool of sources, some noise
  task automatic send_random_item();
    int r;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(99);
    if (r < 50) begin
      send_item(OP_ACQUIRE, addr_pool[$urandom_range(POOL_N - 1)]);
    end else if (r < 85) begin
      if (!pick_open_source(a)) a = addr_pool[$urandom_range(POOL_N - 1)];
      send_item(OP_RELEASE, a);
    end else if (r < 93) begin
      send_item(OP_RELEASE, $urandom());
    end else begin
      send_item(OP_ACQUIRE, $urandom());
    end
  endtask

  task automatic test_random();
    int p;
    int n;
    int k;
    logic [ADDR_W-1:0] base;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    addr_pool[2] = 32'h8000_0000;
    addr_pool[3] = 32'h7FFF_FFFF;
    // near neighbours: one bit away from a common base
    base = $urandom();
    for (k = 0; k < 11; k++) addr_pool[4 + k] = base ^ (32'h1 << (k * 3));
    for (k = 15; k < POOL_N; k++) addr_pool[k] = $urandom();
    for (p = 0; p < RAND_PHASES; p++) begin
      case (p % 6)
        0: set_limits(16'd0, 16'd0);
        1: set_limits(16'd8, 16'd3);
        2: set_limits(16'hFFFF, 16'hFFFF);
        3: set_limits(16'd1, 16'd1);
        4: set_limits(16'd0, 16'd1);
        default: set_limits(LIMIT_W'($urandom_range(2, 60)), LIMIT_W'($urandom_range(0, 6)));
      endcase
      case (p / 3)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 80; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 80; end
        default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) send_random_item();
    end
  endtask

  initial begin
    lim_total  = '0;
    lim_source = '0;
    open_count = '0;
    for (int i = 0; i < TABLE_N; i++) begin
      slot_used[i]  = 1'b0;
      slot_addr[i]  = '0;
      slot_count[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_table_full();
    test_backpressure();
    test_random();

    drain();
    repeat (2 * ITEM_CYCLES) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
